// ----- hw/rtl/sctd_pkg.sv -----
`default_nettype none

package sctd_pkg;

    // Calendar constants
    localparam int SECS_PER_MIN   = 60;
    localparam int MINS_PER_HOUR  = 60;
    localparam int HOURS_PER_DAY  = 24;
    localparam int DAYS_COMMON    = 365;
    localparam int DAYS_LEAP      = 366;
    localparam int DAYS_PER_GROUP = 4 * DAYS_COMMON + 1;

    // Field widths
    localparam int SECS_W  = 32;
    localparam int MINS_W  = 27;   // total minutes, below 2^32 / 60
    localparam int HOURS_W = 21;   // total hours
    localparam int DAYS_W  = 16;   // total days, at most 49710
    localparam int GROUP_W = 6;    // four-year groups, at most 34
    localparam int GREM_W  = 11;   // day within a four-year group
    localparam int YEAR_W  = 8;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int DOY_W   = 9;    // day within the year, from 0

    // Time of day carried alongside the date work
    localparam int TOD_W = HOUR_W + MIN_W + SEC_W;

    // First day of each later year inside a four-year group (first year is the leap one)
    localparam logic [GREM_W-1:0] GROUP_Y1 = GREM_W'(DAYS_LEAP);
    localparam logic [GREM_W-1:0] GROUP_Y2 = GREM_W'(DAYS_LEAP + DAYS_COMMON);
    localparam logic [GREM_W-1:0] GROUP_Y3 = GREM_W'(DAYS_LEAP + 2 * DAYS_COMMON);

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Day of the year on which a month starts; February has 29 days in a leap year
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
        logic [DOY_W-1:0] base;
        case (month)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (month > MONTH_FEB)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/seconds_to_calendar_date_top.sv -----
`default_nettype none

// Converts a 32-bit count of seconds since 2000-01-01 00:00:00 into year
// offset, month, day, hour, minute and second, under the rule that every
// year divisible by four is a leap year. One request enters per clock while
// o_in_stall is low, and passes through four constant dividers (by 60, 60, 24
// and 1461 days per four-year group) of two stages each, one stage that splits
// the group into years and two stages that walk the month table. Each stage takes
// a new request whenever it is empty or its successor moves, so bubbles fill
// while a finished result waits at the output.
module seconds_to_calendar_date_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [31:0]                     i_seconds_count,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [7:0]                           o_year_offset,
    output logic [3:0]                           o_month_number,
    output logic [4:0]                           o_day_of_month,
    output logic [4:0]                           o_hour_of_day,
    output logic [5:0]                           o_minute_of_hour,
    output logic [5:0]                           o_second_of_minute
);

    logic                             w_m_valid, w_m_stall;
    logic [sctd_pkg::MINS_W-1:0]      w_m_mins;
    logic [sctd_pkg::SEC_W-1:0]       w_m_sec;

    logic                             w_h_valid, w_h_stall;
    logic [sctd_pkg::HOURS_W-1:0]     w_h_hours;
    logic [sctd_pkg::MIN_W-1:0]       w_h_min;
    logic [sctd_pkg::SEC_W-1:0]       w_h_sec;

    logic                             w_d_valid, w_d_stall;
    logic [sctd_pkg::DAYS_W-1:0]      w_d_days;
    logic [sctd_pkg::HOUR_W-1:0]      w_d_hour;
    logic [sctd_pkg::MIN_W+sctd_pkg::SEC_W-1:0] w_d_ms;

    logic                             w_g_valid, w_g_stall;
    logic [sctd_pkg::GROUP_W-1:0]     w_g_group;
    logic [sctd_pkg::GREM_W-1:0]      w_g_grem;
    logic [sctd_pkg::TOD_W-1:0]       w_g_tod;

    logic                             w_y_valid, w_y_stall;
    logic [sctd_pkg::YEAR_W-1:0]      w_y_year;
    logic [sctd_pkg::DOY_W-1:0]       w_y_doy;
    logic                             w_y_leap;
    logic [sctd_pkg::TOD_W-1:0]       w_y_tod;

    logic [sctd_pkg::TOD_W-1:0]       w_o_tod;

    // Seconds to minutes
    sctd_cdiv #(
        .NUM_W   (sctd_pkg::SECS_W),
        .QUO_W   (sctd_pkg::MINS_W),
        .DIVISOR (sctd_pkg::SECS_PER_MIN),
        .SIDE_W  (1)
    ) u_div_sec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_num   (i_seconds_count),
        .i_side  (1'b0),
        .o_valid (w_m_valid),
        .i_stall (w_m_stall),
        .o_quo   (w_m_mins),
        .o_rem   (w_m_sec),
        .o_side  ()
    );

    // Minutes to hours
    sctd_cdiv #(
        .NUM_W   (sctd_pkg::MINS_W),
        .QUO_W   (sctd_pkg::HOURS_W),
        .DIVISOR (sctd_pkg::MINS_PER_HOUR),
        .SIDE_W  (sctd_pkg::SEC_W)
    ) u_div_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_m_valid),
        .o_stall (w_m_stall),
        .i_num   (w_m_mins),
        .i_side  (w_m_sec),
        .o_valid (w_h_valid),
        .i_stall (w_h_stall),
        .o_quo   (w_h_hours),
        .o_rem   (w_h_min),
        .o_side  (w_h_sec)
    );

    // Hours to days
    sctd_cdiv #(
        .NUM_W   (sctd_pkg::HOURS_W),
        .QUO_W   (sctd_pkg::DAYS_W),
        .DIVISOR (sctd_pkg::HOURS_PER_DAY),
        .SIDE_W  (sctd_pkg::MIN_W + sctd_pkg::SEC_W)
    ) u_div_hour (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_h_valid),
        .o_stall (w_h_stall),
        .i_num   (w_h_hours),
        .i_side  ({w_h_min, w_h_sec}),
        .o_valid (w_d_valid),
        .i_stall (w_d_stall),
        .o_quo   (w_d_days),
        .o_rem   (w_d_hour),
        .o_side  (w_d_ms)
    );

    // Days to four-year groups
    sctd_cdiv #(
        .NUM_W   (sctd_pkg::DAYS_W),
        .QUO_W   (sctd_pkg::GROUP_W),
        .DIVISOR (sctd_pkg::DAYS_PER_GROUP),
        .SIDE_W  (sctd_pkg::TOD_W)
    ) u_div_group (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .o_stall (w_d_stall),
        .i_num   (w_d_days),
        .i_side  ({w_d_hour, w_d_ms}),
        .o_valid (w_g_valid),
        .i_stall (w_g_stall),
        .o_quo   (w_g_group),
        .o_rem   (w_g_grem),
        .o_side  (w_g_tod)
    );

    // Year within the group
    sctd_year u_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_g_valid),
        .o_stall (w_g_stall),
        .i_group (w_g_group),
        .i_grem  (w_g_grem),
        .i_tod   (w_g_tod),
        .o_valid (w_y_valid),
        .i_stall (w_y_stall),
        .o_year  (w_y_year),
        .o_doy   (w_y_doy),
        .o_leap  (w_y_leap),
        .o_tod   (w_y_tod)
    );

    // Month and day; the last stage is the output register
    sctd_month u_month (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_y_valid),
        .o_stall (w_y_stall),
        .i_year  (w_y_year),
        .i_doy   (w_y_doy),
        .i_leap  (w_y_leap),
        .i_tod   (w_y_tod),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_year  (o_year_offset),
        .o_month (o_month_number),
        .o_day   (o_day_of_month),
        .o_tod   (w_o_tod)
    );

    // Unpack time of day
    assign o_hour_of_day      = w_o_tod[sctd_pkg::TOD_W-1 -: sctd_pkg::HOUR_W];
    assign o_minute_of_hour   = w_o_tod[sctd_pkg::SEC_W +: sctd_pkg::MIN_W];
    assign o_second_of_minute = w_o_tod[sctd_pkg::SEC_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/sctd_cdiv.sv -----
`default_nettype none

// Divide by a constant in two stages: reciprocal multiply, then one
// compare-and-subtract that fixes the quotient and yields the remainder.
module sctd_cdiv #(
    parameter int NUM_W   = 32,
    parameter int QUO_W   = 27,
    parameter int DIVISOR = 60,
    parameter int SIDE_W  = 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [NUM_W-1:0]            i_num,
    input  wire logic [SIDE_W-1:0]           i_side,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [QUO_W-1:0]                 o_quo,
    output logic [$clog2(DIVISOR)-1:0]       o_rem,
    output logic [SIDE_W-1:0]                o_side
);

    localparam int REM_W  = $clog2(DIVISOR);
    localparam int PROD_W = 2 * NUM_W;
    // floor(2^NUM_W / DIVISOR): the estimate is low by at most one
    localparam longint unsigned MULT_FULL = (64'd1 << NUM_W) / DIVISOR;
    localparam logic [NUM_W-1:0] MULT = NUM_W'(MULT_FULL);
    localparam logic [REM_W:0] DIV_R = (REM_W + 1)'(DIVISOR);

    logic                r_a_valid;
    logic [NUM_W-1:0]    r_a_num;
    logic [QUO_W-1:0]    r_a_quo;
    logic [SIDE_W-1:0]   r_a_side;
    logic                r_b_valid;
    logic [QUO_W-1:0]    r_b_quo;
    logic [REM_W-1:0]    r_b_rem;
    logic [SIDE_W-1:0]   r_b_side;

    logic                w_en_a;
    logic                w_en_b;
    logic [PROD_W-1:0]   w_prod;
    logic [NUM_W-1:0]    w_diff;
    logic [REM_W:0]      w_diff_n;
    logic                w_over;
    logic [QUO_W-1:0]    n_quo;
    logic [REM_W-1:0]    n_rem;

    // Advance a stage when it is empty or the next one moves
    assign w_en_b  = !r_b_valid || !i_stall;
    assign w_en_a  = !r_a_valid || w_en_b;
    assign o_stall = !w_en_a;

    // Estimate the quotient
    assign w_prod = PROD_W'(i_num) * PROD_W'(MULT);

    // Correct the estimate
    assign w_diff   = r_a_num - NUM_W'(r_a_quo) * NUM_W'(DIVISOR);
    assign w_diff_n = w_diff[REM_W:0];
    assign w_over   = (w_diff_n >= DIV_R);
    assign n_quo    = w_over ? (r_a_quo + QUO_W'(1)) : r_a_quo;
    assign n_rem    = w_over ? REM_W'(w_diff_n - DIV_R) : w_diff_n[REM_W-1:0];

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_a_valid <= i_valid;
            end
            if (w_en_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_num  <= i_num;
            r_a_quo  <= w_prod[NUM_W +: QUO_W];
            r_a_side <= i_side;
        end
        if (w_en_b) begin
            r_b_quo  <= n_quo;
            r_b_rem  <= n_rem;
            r_b_side <= r_a_side;
        end
    end

    assign o_valid = r_b_valid;
    assign o_quo   = r_b_quo;
    assign o_rem   = r_b_rem;
    assign o_side  = r_b_side;

endmodule

`default_nettype wire

// ----- hw/rtl/sctd_year.sv -----
`default_nettype none

// Split the day within a four-year group into year and day of year.
module sctd_year (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [sctd_pkg::GROUP_W-1:0]    i_group,
    input  wire logic [sctd_pkg::GREM_W-1:0]     i_grem,
    input  wire logic [sctd_pkg::TOD_W-1:0]      i_tod,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [sctd_pkg::YEAR_W-1:0]          o_year,
    output logic [sctd_pkg::DOY_W-1:0]           o_doy,
    output logic                                 o_leap,
    output logic [sctd_pkg::TOD_W-1:0]           o_tod
);

    logic                             r_valid;
    logic [sctd_pkg::YEAR_W-1:0]      r_year;
    logic [sctd_pkg::DOY_W-1:0]       r_doy;
    logic                             r_leap;
    logic [sctd_pkg::TOD_W-1:0]       r_tod;

    logic                             w_en;
    logic [1:0]                       w_yig;
    logic [sctd_pkg::GREM_W-1:0]      w_base;
    logic [sctd_pkg::GREM_W-1:0]      w_doy;

    assign w_en    = !r_valid || !i_stall;
    assign o_stall = !w_en;

    // Pick the year inside the group; the first one is the leap year
    always_comb begin
        if (i_grem >= sctd_pkg::GROUP_Y3) begin
            w_yig  = 2'd3;
            w_base = sctd_pkg::GROUP_Y3;
        end else if (i_grem >= sctd_pkg::GROUP_Y2) begin
            w_yig  = 2'd2;
            w_base = sctd_pkg::GROUP_Y2;
        end else if (i_grem >= sctd_pkg::GROUP_Y1) begin
            w_yig  = 2'd1;
            w_base = sctd_pkg::GROUP_Y1;
        end else begin
            w_yig  = 2'd0;
            w_base = '0;
        end
    end

    assign w_doy = i_grem - w_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_year <= {i_group, w_yig};
            r_doy  <= w_doy[sctd_pkg::DOY_W-1:0];
            r_leap <= (w_yig == 2'd0);
            r_tod  <= i_tod;
        end
    end

    assign o_valid = r_valid;
    assign o_year  = r_year;
    assign o_doy   = r_doy;
    assign o_leap  = r_leap;
    assign o_tod   = r_tod;

endmodule

`default_nettype wire

// ----- hw/rtl/sctd_month.sv -----
`default_nettype none

// Turn day of year into month and day of month: compare against the
// month starts, then subtract the chosen start.
module sctd_month (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [sctd_pkg::YEAR_W-1:0]     i_year,
    input  wire logic [sctd_pkg::DOY_W-1:0]      i_doy,
    input  wire logic                            i_leap,
    input  wire logic [sctd_pkg::TOD_W-1:0]      i_tod,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [sctd_pkg::YEAR_W-1:0]          o_year,
    output logic [sctd_pkg::MONTH_W-1:0]         o_month,
    output logic [sctd_pkg::DAY_W-1:0]           o_day,
    output logic [sctd_pkg::TOD_W-1:0]           o_tod
);

    logic                             r_c_valid;
    logic [sctd_pkg::YEAR_W-1:0]      r_c_year;
    logic [sctd_pkg::MONTH_W-1:0]     r_c_month;
    logic [sctd_pkg::DOY_W-1:0]       r_c_doy;
    logic                             r_c_leap;
    logic [sctd_pkg::TOD_W-1:0]       r_c_tod;
    logic                             r_d_valid;
    logic [sctd_pkg::YEAR_W-1:0]      r_d_year;
    logic [sctd_pkg::MONTH_W-1:0]     r_d_month;
    logic [sctd_pkg::DAY_W-1:0]       r_d_day;
    logic [sctd_pkg::TOD_W-1:0]       r_d_tod;

    logic                             w_en_c;
    logic                             w_en_d;
    logic [sctd_pkg::MONTH_W-1:0]     n_month;
    logic [sctd_pkg::DOY_W-1:0]       w_day0;

    assign w_en_d  = !r_d_valid || !i_stall;
    assign w_en_c  = !r_c_valid || w_en_d;
    assign o_stall = !w_en_c;

    // Count the month starts already passed
    always_comb begin
        n_month = 4'd1;
        for (int m = 2; m <= 12; m++) begin
            if (i_doy >= sctd_pkg::month_start(sctd_pkg::MONTH_W'(m), i_leap)) begin
                n_month = n_month + 4'd1;
            end
        end
    end

    // Day within the month, counted from one
    assign w_day0 = r_c_doy - sctd_pkg::month_start(r_c_month, r_c_leap) + 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_en_c) begin
                r_c_valid <= i_valid;
            end
            if (w_en_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_c) begin
            r_c_year  <= i_year;
            r_c_month <= n_month;
            r_c_doy   <= i_doy;
            r_c_leap  <= i_leap;
            r_c_tod   <= i_tod;
        end
        if (w_en_d) begin
            r_d_year  <= r_c_year;
            r_d_month <= r_c_month;
            r_d_day   <= w_day0[sctd_pkg::DAY_W-1:0];
            r_d_tod   <= r_c_tod;
        end
    end

    assign o_valid = r_d_valid;
    assign o_year  = r_d_year;
    assign o_month = r_d_month;
    assign o_day   = r_d_day;
    assign o_tod   = r_d_tod;

endmodule

`default_nettype wire
